>>> sv/assert_macros.svh
// Assertion macros shared by the priority queue RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/spq_pkg.sv
// Types and constants for the sorted priority queue.
// No dependencies; used by the cell and the top level.
package spq_pkg;

  localparam int ID_W  = 8;
  localparam int KEY_W = 16;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } spq_cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic signed [KEY_W-1:0] key;
  } spq_entry_t;

  // Broadcast from the top level to every cell in the chain.
  typedef struct packed {
    logic       ins;
    logic       rem;
    spq_entry_t new_entry;
  } spq_ctrl_t;

endpackage

>>> sv/spq_in_if.sv
// Input channel of the priority queue: valid/ready handshake plus command item.
// No dependencies.
interface spq_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [7:0]         item_id;
  logic signed [15:0] priority_req;

  modport source (output valid, cmd, item_id, priority_req, input ready);
  modport sink   (input valid, cmd, item_id, priority_req, output ready);
endinterface

>>> sv/spq_out_if.sv
// Result channel of the priority queue: valid/ready handshake plus result item.
// No dependencies.
interface spq_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] removed_id;
  logic       was_empty;
  logic       overflow;
  logic       now_empty;

  modport source (output valid, removed_id, was_empty, overflow, now_empty, input ready);
  modport sink   (input valid, removed_id, was_empty, overflow, now_empty, output ready);
endinterface

>>> sv/spq_cell.sv
// One slot of the sorted shift-register queue.
// Depends on spq_pkg; instantiated in a chain by sorted_priority_queue.
module spq_cell (
  input  logic                   clk,
  input  spq_pkg::spq_ctrl_t     ctrl,
  input  logic                   occupied,
  input  spq_pkg::spq_entry_t    left_entry,
  input  logic                   left_keep,
  input  spq_pkg::spq_entry_t    right_entry,
  output spq_pkg::spq_entry_t    entry,
  output logic                   keep
);

  spq_pkg::spq_entry_t entry_r;
  spq_pkg::spq_entry_t entry_nxt;

  // Entry stays put on insert when it sorts strictly ahead of the new key.
  assign keep  = occupied && (entry_r.key < ctrl.new_entry.key);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins) begin
      if (keep) begin
        entry_nxt = entry_r;
      end else if (left_keep) begin
        entry_nxt = ctrl.new_entry;
      end else begin
        entry_nxt = left_entry;
      end
    end else if (ctrl.rem) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

>>> sv/sorted_priority_queue.sv
// Sorted min-priority queue built as a chain of compare-and-shift cells.
// Depends on spq_pkg, spq_in_if, spq_out_if, spq_cell and assert_macros.svh.
//
// Usage:
//   in_ch  (sink):   cmd 0 inserts item_id with signed priority_req, cmd 1 removes
//                    the entry with the smallest priority. Equal priorities leave
//                    newest first.
//   out_ch (source): one result per item: removed_id, was_empty, overflow and
//                    now_empty (queue empty after the item).
// Result: registered, and shows in the cycle after the item is taken.
// Throughput: one item per cycle when not stalled. Every cell compares its key
//   with the new key and shifts left or right in the same cycle; cells set the pace.
// Stall: in_ch.ready drops while an undelivered result sits in the output
//   register and out_ch.ready is low; it rises again in the cycle the result
//   is taken, so an item can enter while the old result leaves.
// Reset: synchronous, active low; the queue comes up empty and no result pending.
//   A full-queue insert is dropped with overflow set; a remove from an empty
//   queue returns id zero with was_empty set.
`include "assert_macros.svh"

module sorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input logic      clk,
  input logic      rst_n,
  spq_in_if.sink   in_ch,
  spq_out_if.source out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [7:0]          removed_id_r;
  logic [7:0]          removed_id_nxt;
  logic                was_empty_r;
  logic                was_empty_nxt;
  logic                overflow_r;
  logic                overflow_nxt;
  logic                now_empty_r;
  logic                now_empty_nxt;

  logic                accept;
  logic                is_full;
  logic                is_empty;
  spq_pkg::spq_ctrl_t  ctrl;

  spq_pkg::spq_entry_t cell_entry [CAPACITY];
  logic                cell_keep  [CAPACITY];

  assign accept   = in_ch.valid && in_ch.ready;
  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);

  assign in_ch.ready = !out_valid_r || out_ch.ready;

  assign ctrl.ins = accept && (in_ch.cmd == spq_pkg::CMD_INSERT) && !is_full;
  assign ctrl.rem = accept && (in_ch.cmd == spq_pkg::CMD_REMOVE) && !is_empty;
  assign ctrl.new_entry.id  = in_ch.item_id;
  assign ctrl.new_entry.key = in_ch.priority_req;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_pkg::spq_entry_t left_entry;
    spq_pkg::spq_entry_t right_entry;
    logic                left_keep;
    logic                occupied;

    assign occupied = (count_r > CNT_W'(i));

    if (i == 0) begin : g_head
      assign left_entry = '0;
      assign left_keep  = 1'b1;
    end else begin : g_body
      assign left_entry = cell_entry[i-1];
      assign left_keep  = cell_keep[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occupied),
      .left_entry  (left_entry),
      .left_keep   (left_keep),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .keep        (cell_keep[i])
    );
  end

  always_comb begin
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r;
    removed_id_nxt = removed_id_r;
    was_empty_nxt  = was_empty_r;
    overflow_nxt   = overflow_r;
    now_empty_nxt  = now_empty_r;
    if (ctrl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt  = 1'b1;
      removed_id_nxt = ctrl.rem ? cell_entry[0].id : 8'd0;
      was_empty_nxt  = (in_ch.cmd == spq_pkg::CMD_REMOVE) && is_empty;
      overflow_nxt   = (in_ch.cmd == spq_pkg::CMD_INSERT) && is_full;
      now_empty_nxt  = (count_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    removed_id_r <= removed_id_nxt;
    was_empty_r  <= was_empty_nxt;
    overflow_r   <= overflow_nxt;
    now_empty_r  <= now_empty_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.removed_id = removed_id_r;
  assign out_ch.was_empty  = was_empty_r;
  assign out_ch.overflow   = overflow_r;
  assign out_ch.now_empty  = now_empty_r;

  `SPQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(CAPACITY), "count above capacity")
  `SPQ_ASSERT_NXT(a_empty_remove, clk, rst_n, accept && (in_ch.cmd == spq_pkg::CMD_REMOVE) && is_empty, out_valid_r && was_empty_r && (count_r == '0), "empty remove not flagged")
  `SPQ_ASSERT_NXT(a_full_insert, clk, rst_n, accept && (in_ch.cmd == spq_pkg::CMD_INSERT) && is_full, overflow_r && (count_r == $past(count_r)), "full insert changed queue")
  `SPQ_ASSERT_IMP(a_now_empty, clk, rst_n, out_valid_r, now_empty_r == (count_r == '0), "now_empty disagrees with count")

endmodule

>>> test/tb_top.sv
// Self-checking testbench for sorted_priority_queue: directed and random insert/remove
// traffic with bursty input and a stalling result side, checked against a shadow sorted list.
// Depends on spq_pkg, spq_in_if, spq_out_if and the RTL of the queue.
module tb_top;

  localparam int QUEUE_DEPTH = 16;

  typedef struct packed {
    logic [7:0] removed_id;
    logic       was_empty;
    logic       overflow;
    logic       now_empty;
  } queue_outcome_t;

  logic clk = 1'b0;
  logic rst_n;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  sorted_priority_queue #(.CAPACITY(QUEUE_DEPTH)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow of the sorted list, slot 0 is the front
  logic [7:0]         shadow_ids  [QUEUE_DEPTH];
  logic signed [15:0] shadow_keys [QUEUE_DEPTH];
  int                 shadow_fill = 0;

  queue_outcome_t pending_outcomes[$];
  int             error_count = 0;

  int gap_max;
  int stall_pct;
  int burst_left;

  always #10 clk = ~clk;

  function automatic queue_outcome_t apply_queue_op(spq_pkg::spq_cmd_t op, logic [7:0] id,
                                                    logic signed [15:0] key);
    queue_outcome_t res;
    int pos;
    res = '0;
    if (op == spq_pkg::CMD_INSERT) begin
      if (shadow_fill >= QUEUE_DEPTH) begin
        res.overflow = 1'b1;
      end else begin
        pos = 0;
        while (pos < shadow_fill && shadow_keys[pos] < key) pos++;
        for (int i = shadow_fill; i > pos; i--) begin
          shadow_ids[i]  = shadow_ids[i-1];
          shadow_keys[i] = shadow_keys[i-1];
        end
        shadow_ids[pos]  = id;
        shadow_keys[pos] = key;
        shadow_fill++;
      end
    end else begin
      if (shadow_fill == 0) begin
        res.was_empty = 1'b1;
      end else begin
        res.removed_id = shadow_ids[0];
        for (int i = 1; i < shadow_fill; i++) begin
          shadow_ids[i-1]  = shadow_ids[i];
          shadow_keys[i-1] = shadow_keys[i];
        end
        shadow_fill--;
      end
    end
    res.now_empty = (shadow_fill == 0);
    return res;
  endfunction

  task automatic compare_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
      error_count++;
    end
  endtask

  // result checker and input monitor
  always @(posedge clk) begin
    queue_outcome_t exp_res;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_outcomes.size() == 0) begin
          $display("%0t: unexpected result, expected none actual id %0d", $time,
                   out_ch.removed_id);
          error_count++;
        end else begin
          exp_res = pending_outcomes.pop_front();
          compare_field("removed_id", exp_res.removed_id, out_ch.removed_id);
          compare_field("was_empty", {7'd0, exp_res.was_empty}, {7'd0, out_ch.was_empty});
          compare_field("overflow", {7'd0, exp_res.overflow}, {7'd0, out_ch.overflow});
          compare_field("now_empty", {7'd0, exp_res.now_empty}, {7'd0, out_ch.now_empty});
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_outcomes.push_back(apply_queue_op(spq_pkg::spq_cmd_t'(in_ch.cmd),
                                                  in_ch.item_id, in_ch.priority_req));
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send_item(spq_pkg::spq_cmd_t op, logic [7:0] id, logic signed [15:0] key);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid        = 1'b1;
    in_ch.cmd          = op;
    in_ch.item_id      = id;
    in_ch.priority_req = key;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic run_traffic(int count);
    int insert_pct;
    int seg_left;
    int pick;
    spq_pkg::spq_cmd_t op;
    logic signed [15:0] key;
    seg_left = 0;
    insert_pct = 50;
    for (int n = 0; n < count; n++) begin
      if (seg_left == 0) begin
        pick = $urandom_range(0, 2);
        insert_pct = (pick == 0) ? 15 : (pick == 1) ? 50 : 85;
        seg_left = $urandom_range(10, 60);
      end
      seg_left--;
      op = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::CMD_INSERT : spq_pkg::CMD_REMOVE;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        key = $signed(16'($urandom_range(0, 8))) - 16'sd4;
      end else if (pick == 4) begin
        case ($urandom_range(0, 3))
          0: key = -16'sd32768;
          1: key = 16'sd32767;
          2: key = -16'sd32767;
          default: key = 16'sd32766;
        endcase
      end else begin
        key = 16'($urandom());
      end
      send_item(op, 8'($urandom_range(0, 255)), key);
    end
  endtask

  task automatic test_empty_remove();
    send_item(spq_pkg::CMD_REMOVE, 8'hFF, -16'sd32768);
    send_item(spq_pkg::CMD_REMOVE, 8'h00, 16'sd32767);
    send_item(spq_pkg::CMD_INSERT, 8'hAA, 16'sd0);
    send_item(spq_pkg::CMD_REMOVE, 8'h55, 16'sd0);
    send_item(spq_pkg::CMD_REMOVE, 8'h00, 16'sd0);
  endtask

  // fill to capacity with extremes and equal keys, overflow, then pull a few
  task automatic test_order_and_overflow();
    logic [7:0] ids [QUEUE_DEPTH] = '{8'd1, 8'd255, 8'd0, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8,
                                      8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14, 8'd15,
                                      8'd128};
    logic signed [15:0] keys [QUEUE_DEPTH] = '{16'sd32767, -16'sd32768, 16'sd0, 16'sd0,
                                               16'sd0, -16'sd1, 16'sd1, 16'sd32767,
                                               -16'sd32768, 16'sd100, -16'sd100, 16'sd5,
                                               16'sd5, -16'sd32768, 16'sd32767, 16'sd0};
    for (int i = 0; i < QUEUE_DEPTH; i++) send_item(spq_pkg::CMD_INSERT, ids[i], keys[i]);
    send_item(spq_pkg::CMD_INSERT, 8'h77, -16'sd32768);
    repeat (3) send_item(spq_pkg::CMD_REMOVE, 8'h00, 16'sd0);
  endtask

  task automatic test_back_to_back();
    gap_max = 0;
    stall_pct = 0;
    run_traffic(250);
  endtask

  task automatic test_random_idle();
    gap_max = 6;
    stall_pct = 30;
    run_traffic(500);
  endtask

  task automatic test_heavy_stall();
    gap_max = 2;
    stall_pct = 75;
    run_traffic(250);
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = spq_pkg::CMD_INSERT;
    in_ch.item_id      = '0;
    in_ch.priority_req = '0;
    gap_max            = 3;
    stall_pct          = 20;
    burst_left         = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_empty_remove();
    test_order_and_overflow();
    test_back_to_back();
    test_random_idle();
    test_heavy_stall();

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/spq_pkg.sv
sv/spq_in_if.sv
sv/spq_out_if.sv
sv/spq_cell.sv
sv/sorted_priority_queue.sv
test/tb_top.sv
